// ===== rtl/base64_encoder_line_wrap_defines.svh =====
// Assertion macros shared by the encoder RTL.
// Each macro is a concurrent assertion clocked on the rising edge and
// disabled while the asynchronous active-low reset is asserted.
`ifndef BASE64_ENCODER_LINE_WRAP_DEFINES_SVH
`define BASE64_ENCODER_LINE_WRAP_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside reset.
`define B64LW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Checks that a condition never holds at a clock edge outside reset.
`define B64LW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define B64LW_ASSERT(label, clk, rst_n, prop, msg)
`define B64LW_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/b64lw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package b64lw_pkg;

  // Special characters of the encoded stream.
  localparam logic [7:0] CHAR_PAD     = 8'h3D;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Reset value of the line length register.
  localparam logic [7:0] LINE_LEN_RESET = 8'd72;

  // Positions of characters within one group's output.
  localparam logic [2:0] POS_FIRST    = 3'd0;
  localparam logic [2:0] POS_SECOND   = 3'd1;
  localparam logic [2:0] POS_THIRD    = 3'd2;
  localparam logic [2:0] POS_FOURTH   = 3'd3;
  localparam logic [2:0] POS_NEWLINE  = 3'd4;

  // Number of real bytes in a group.
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // One classified group handed from the front to the back.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] len;
    logic       nl;
  } group_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Maps a 6-bit value onto the standard alphabet.
  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'b00, v};
    if (v < 6'd26) begin
      r = 8'h41 + w;
    end else if (v < 6'd52) begin
      r = 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b64lw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64lw_front
  import b64lw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output logic            s_ready_o,
  input  wire logic [7:0] s_data_i,
  input  wire logic       s_final_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  input  q_status_t       q_status_i,
  output logic            push_o,
  output group_t          group_o
);

  logic [7:0] held_q [2];
  logic [1:0] held_cnt_q;
  logic [7:0] col_q;
  logic [7:0] len_q;

  logic       accept;
  logic       complete;
  logic [1:0] cnt_inc;
  logic [8:0] col_sum;
  logic       nl;

  // A byte is taken whenever the queue has room for a group.
  assign s_ready_o   = !q_status_i.full;
  assign cfg_ready_o = 1'b1;
  assign accept      = s_valid_i && s_ready_o;
  assign cnt_inc     = held_cnt_q + 2'd1;
  assign complete    = s_final_i || (held_cnt_q == LEN_TWO);

  // The newline test uses the grown count before it is stored.
  assign col_sum = {1'b0, col_q} + 9'd4;
  assign nl      = (col_sum >= {1'b0, len_q});

  // Build the group from the held bytes and the incoming one.
  always_comb begin
    group_o.len = cnt_inc;
    group_o.nl  = nl;
    group_o.b0  = (cnt_inc == LEN_ONE) ? s_data_i : held_q[0];
    if (cnt_inc == LEN_TWO) begin
      group_o.b1 = s_data_i;
    end else if (cnt_inc == LEN_THREE) begin
      group_o.b1 = held_q[1];
    end else begin
      group_o.b1 = 8'd0;
    end
    group_o.b2 = (cnt_inc == LEN_THREE) ? s_data_i : 8'd0;
  end

  assign push_o = accept && complete;

  // Line length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LINE_LEN_RESET;
    end else if (cfg_valid_i) begin
      len_q <= cfg_data_i;
    end
  end

  // Pending bytes, their count and the line column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q[0]  <= 8'd0;
      held_q[1]  <= 8'd0;
      held_cnt_q <= 2'd0;
      col_q      <= 8'd0;
    end else if (accept) begin
      if (complete) begin
        held_q[0]  <= 8'd0;
        held_q[1]  <= 8'd0;
        held_cnt_q <= 2'd0;
        col_q      <= (s_final_i || nl) ? 8'd0 : col_sum[7:0];
      end else begin
        held_q[held_cnt_q[0]] <= s_data_i;
        held_cnt_q            <= cnt_inc;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64lw_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64lw_fifo
  import b64lw_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  group_t    data_i,
  input  wire logic pop_i,
  output group_t    head_o,
  output q_status_t status_o
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  group_t          mem_q [DEPTH];
  logic [IdxW-1:0] wr_ptr_q;
  logic [IdxW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  // Storage for queued groups.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64lw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64lw_back
  import b64lw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  group_t          head_i,
  input  q_status_t       q_status_i,
  output logic            pop_o,
  output logic            m_valid_o,
  input  wire logic       m_ready_i,
  output logic [7:0]      m_data_o,
  output logic            m_last_o
);

  logic [2:0] pos_q;
  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;

  logic       load;
  logic       last;
  logic [7:0] chr;
  logic [5:0] s0, s1, s2, s3;

  // Split the group into four sextets.
  assign s0 = head_i.b0[7:2];
  assign s1 = {head_i.b0[1:0], head_i.b1[7:4]};
  assign s2 = {head_i.b1[3:0], head_i.b2[7:6]};
  assign s3 = head_i.b2[5:0];

  // Select the character at the current position.
  always_comb begin
    case (pos_q)
      POS_FIRST:   chr = b64_sym(s0);
      POS_SECOND:  chr = b64_sym(s1);
      POS_THIRD:   chr = (head_i.len > LEN_ONE) ? b64_sym(s2) : CHAR_PAD;
      POS_FOURTH:  chr = (head_i.len > LEN_TWO) ? b64_sym(s3) : CHAR_PAD;
      POS_NEWLINE: chr = CHAR_NEWLINE;
      default:     chr = CHAR_NEWLINE;
    endcase
  end

  assign last  = ((pos_q == POS_FOURTH) && !head_i.nl) || (pos_q == POS_NEWLINE);
  assign load  = !q_status_i.empty && (!valid_q || m_ready_i);
  assign pop_o = load && last;

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_last_o  = last_q;

  // Output register; a new word loads as the previous one is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= POS_FIRST;
    end else if (load) begin
      valid_q <= 1'b1;
      pos_q   <= last ? POS_FIRST : pos_q + 3'd1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= chr;
      last_q <= last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/base64_encoder_line_wrap.sv =====
// Base64 encoder with line wrapping.
// A completed group is stored in the group queue, then its characters are loaded one
// at a time into the output register; one character leaves per cycle while the
// queue holds a group and the receiver is ready. Each group gives four characters, or
// five with a newline. Bytes enter at one per cycle while the group queue has room.
// Reset clears the control state and restores a line length of 72.
`timescale 1ns / 1ps
`default_nettype none
`include "base64_encoder_line_wrap_defines.svh"

module base64_encoder_line_wrap
  import b64lw_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,   // is_final
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_char
  output logic            m_axis_tlast,   // run_end
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i      // line_length
);

  group_t    push_group;
  group_t    head_group;
  q_status_t q_status;
  logic      push;
  logic      pop;
  logic      nl_out;

  // Front: gathers bytes into groups and decides on the newline.
  b64lw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_final_i   (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .group_o     (push_group)
  );

  // Group queue between the two sides.
  b64lw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_group),
    .pop_i    (pop),
    .head_o   (head_group),
    .status_o (q_status)
  );

  // Back: serializes each group into characters.
  b64lw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_group),
    .q_status_i (q_status),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast)
  );

  // A newline word is on the output.
  assign nl_out = m_axis_tvalid && (m_axis_tdata == CHAR_NEWLINE);

  // Queue must never overflow or underflow.
  `B64LW_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && q_status.full, "push into full queue")
  `B64LW_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop && q_status.empty, "pop from empty queue")
  // A newline always closes the characters of its group.
  `B64LW_ASSERT(a_nl_last, clk_i, rst_ni, nl_out |-> m_axis_tlast, "newline without run end")

endmodule

`default_nettype wire

// ===== verif/tb_base64_encoder_line_wrap.sv =====
`timescale 1ns / 1ps

module tb_base64_encoder_line_wrap;
  import b64lw_pkg::*;

  // Cycles with no accepted word on any channel before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Quiet cycles after the last character before a register write or the end.
  localparam int DRAIN_CYCLES = 8;
  // Length of the receiver hold-off that fills the block and stalls its input.
  localparam int RX_HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 10;

  // Standard alphabet, first character in the top byte.
  localparam logic [511:0] B64_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Block ports.
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;    // is_final
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_char
  logic       m_axis_tlast;           // run_end
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = 8'h00;     // line_length

  base64_encoder_line_wrap uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Pending raw bytes and the characters they are expected to produce.
  raw_byte_t byte_stream[$];
  enc_char_t expected_chars[$];

  // Encoder state as predicted by the testbench.
  logic [7:0] grp_bytes [0:1];
  logic [1:0] grp_fill;
  logic [7:0] col_count;
  logic [7:0] wrap_len;

  // Bookkeeping.
  int bytes_queued = 0;
  int bytes_in = 0;
  int msgs_in = 0;
  int chars_checked = 0;
  int newlines_seen = 0;
  int cfg_count = 0;
  int fail_count = 0;
  int stall_cycles = 0;

  // Handshake controls shared between the sequence and the clocked sides.
  logic      in_taken = 1'b0;
  logic      out_taken = 1'b0;
  bit        tx_burst = 1'b0;
  bit        rx_burst = 1'b0;
  bit        rx_hold_req = 1'b0;
  int        tx_gap = 0;
  int        rx_wait = 0;
  int        rx_hold = 0;
  raw_byte_t tx_item;
  enc_char_t next_char;

  // Idle cycles before the next word; none while a burst is requested.
  function automatic int draw_wait(input bit burst);
    if (burst) begin
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    int idx;
    idx = 8 * (63 - int'(v));
    return B64_CHARS[idx +: 8];
  endfunction

  // Predicts the characters that one accepted raw byte causes.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    int unsigned n;
    int          cnt;
    logic [7:0]  b0, b1, b2;
    logic [8:0]  col;
    logic [7:0]  syms [0:4];
    enc_char_t   c;
    n = grp_fill + 1;
    // A byte that leaves the group short and the message open is only held.
    if (n < LEN_THREE && !fin) begin
      grp_bytes[grp_fill[0]] = b;
      grp_fill = n[1:0];
      return;
    end
    b0 = (n == LEN_ONE) ? b : grp_bytes[0];
    b1 = (n == LEN_TWO) ? b : ((n == LEN_THREE) ? grp_bytes[1] : 8'h00);
    b2 = (n == LEN_THREE) ? b : 8'h00;
    syms[0] = sextet_char(b0[7:2]);
    syms[1] = sextet_char({b0[1:0], b1[7:4]});
    syms[2] = (n > LEN_ONE) ? sextet_char({b1[3:0], b2[7:6]}) : CHAR_PAD;
    syms[3] = (n > LEN_TWO) ? sextet_char(b2[5:0]) : CHAR_PAD;
    cnt = 4;
    // The grown count is compared at full width before it is stored.
    col = {1'b0, col_count} + 9'd4;
    if (col >= {1'b0, wrap_len}) begin
      syms[4] = CHAR_NEWLINE;
      cnt = 5;
      col = 9'd0;
    end
    col_count = fin ? 8'd0 : col[7:0];
    grp_fill = 2'd0;
    grp_bytes[0] = 8'h00;
    grp_bytes[1] = 8'h00;
    for (int k = 0; k < cnt; k++) begin
      c.ch = syms[k];
      c.last = (k == cnt - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // Input driver: one raw byte per word, with a drawn gap between words.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_stream.size() > 0) begin
          tx_item = byte_stream.pop_front();
          s_axis_tdata <= tx_item.data;
          s_axis_tlast <= tx_item.fin;
          s_axis_tvalid <= 1'b1;
          tx_gap = draw_wait(tx_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output receiver: a drawn stall after each word, plus an optional long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        rx_wait = draw_wait(rx_burst);
      end
      if (rx_hold_req) begin
        rx_hold = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each accepted byte and checks each accepted character.
  always @(posedge clk_i) begin
    in_taken <= s_axis_tvalid && s_axis_tready;
    out_taken <= m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_byte(s_axis_tdata, s_axis_tlast);
        bytes_in++;
        if (s_axis_tlast) begin
          msgs_in++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $error("out_char: no character expected, got %h", m_axis_tdata);
          fail_count++;
        end else begin
          next_char = expected_chars.pop_front();
          if (m_axis_tdata !== next_char.ch) begin
            $error("out_char: expected %h, got %h", next_char.ch, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tlast !== next_char.last) begin
            $error("run_end: expected %b, got %b", next_char.last, m_axis_tlast);
            fail_count++;
          end
          if (next_char.ch == CHAR_NEWLINE) begin
            newlines_seen++;
          end
          chars_checked++;
        end
      end
    end
  end

  // Watchdog on cycles in which no channel accepts a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no word accepted for %0d cycles, %0d characters outstanding.",
                 STALL_LIMIT, expected_chars.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    raw_byte_t r;
    r.data = b;
    r.fin = fin;
    byte_stream.push_back(r);
    bytes_queued++;
  endtask

  // Queues random messages; the last one is left open unless end_final is set.
  task automatic queue_random(input int n, input bit end_final);
    int         remaining;
    int         len;
    logic [7:0] b;
    remaining = n;
    while (remaining > 0) begin
      len = $urandom_range(1, 10);
      if (len > remaining) begin
        len = remaining;
      end
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 7))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        queue_byte(b, (k == len - 1) && ((len < remaining) || end_final));
      end
      remaining -= len;
    end
  endtask

  // Waits until every queued byte is in and every expected character is out.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (bytes_in != bytes_queued || expected_chars.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_line_length(input logic [7:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    wrap_len = v;
    cfg_count++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  logic [7:0] line_plan [0:RANDOM_PHASES-1];

  initial begin
    grp_bytes[0] = 8'h00;
    grp_bytes[1] = 8'h00;
    grp_fill = 2'd0;
    col_count = 8'd0;
    wrap_len = LINE_LEN_RESET;
    line_plan = '{8'd72, 8'd4, 8'd0, 8'd5, 8'd8, 8'd13, 8'd76, 8'd255, 8'd252, 8'd0};
    line_plan[RANDOM_PHASES-1] = 8'($urandom_range(0, 255));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: one, two and three byte messages at the extremes, reset line length.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    // A complete group without the final flag, then a three byte final group.
    queue_byte(8'h4D, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h6E, 1'b0);
    queue_byte(8'hFC, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hF0, 1'b1);
    wait_idle();

    // Directed: small line lengths put a newline after every group.
    write_line_length(8'd4);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h12, 1'b1);
    wait_idle();
    write_line_length(8'd0);
    queue_byte(8'h80, 1'b1);
    wait_idle();

    // Directed: the line length shrinks in the middle of a line.
    write_line_length(8'd72);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h03, 1'b0);
    wait_idle();
    write_line_length(8'd8);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'h3C, 1'b1);
    wait_idle();

    // Random phases over a spread of line lengths and handshake behaviors.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_line_length(line_plan[p]);
      tx_burst = (p == 2) || (p == 5);
      rx_burst = (p == 5);
      if (p == 2) begin
        rx_hold_req = 1'b1;
        queue_random(24, 1'b1);
      end else begin
        queue_random(12, $urandom_range(0, 2) != 0);
      end
      wait_idle();
    end

    $display("Encoded %0d bytes in %0d messages into %0d characters, %0d of them newlines.",
             bytes_in, msgs_in, chars_checked, newlines_seen);
    $display("Line length was written %0d times, 0 to 255, with bursts and a long output stall.",
             cfg_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/b64lw_pkg.sv
rtl/b64lw_front.sv
rtl/b64lw_fifo.sv
rtl/b64lw_back.sv
rtl/base64_encoder_line_wrap.sv
verif/tb_base64_encoder_line_wrap.sv
